/* hdl/utf8sd_pkg.sv */
// shared types, constants and byte classification for the utf-8 stream decoder
package utf8sd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CNT_W       = 3;
    localparam int FLAG_W      = 4;
    localparam int REM_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FLAG_INVALID   = 0;
    localparam int FLAG_OVERLONG  = 1;
    localparam int FLAG_SURROGATE = 2;
    localparam int FLAG_RANGE     = 3;

    localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
    localparam logic [9:0]      SURROGATE_HIGH = 10'h01B;
    localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'd128;
    localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'd2048;
    localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'd65536;

    typedef enum logic [2:0] {
        CLS_CONT  = 3'd0,
        CLS_ASCII = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_BAD   = 3'd5
    } byte_class_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        byte_class_t       cls;
    } queue_entry_t;

    // class from the top five bits
    function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
        byte_class_t c;
        case (b[7:3]) inside
            [5'd0:5'd15]:  c = CLS_ASCII;
            [5'd16:5'd23]: c = CLS_CONT;
            [5'd24:5'd27]: c = CLS_LEAD2;
            [5'd28:5'd29]: c = CLS_LEAD3;
            5'd30:         c = CLS_LEAD4;
            default:       c = CLS_BAD;
        endcase
        return c;
    endfunction

    // payload bits carried by a lead byte
    function automatic logic [BYTE_W-1:0] lead_mask(input byte_class_t c);
        logic [BYTE_W-1:0] m;
        case (c)
            CLS_ASCII: m = 8'h7F;
            CLS_LEAD2: m = 8'h1F;
            CLS_LEAD3: m = 8'h0F;
            CLS_LEAD4: m = 8'h07;
            default:   m = 8'h00;
        endcase
        return m;
    endfunction

    // value below the smallest one its lead class may encode
    function automatic logic is_overlong(input byte_class_t c, input logic [CP_W-1:0] cp);
        logic o;
        case (c)
            CLS_CONT:  o = 1'b1;
            CLS_LEAD2: o = (cp < MIN_TWO_BYTE);
            CLS_LEAD3: o = (cp < MIN_THREE_BYTE);
            CLS_LEAD4: o = (cp < MIN_FOUR_BYTE);
            default:   o = 1'b0;
        endcase
        return o;
    endfunction

endpackage

/* hdl/utf8_stream_decoder.sv */
// top level of the utf-8 stream decoder: classifier, queue and decoder
//
// input channel: one raw byte per request on byte_in, handshake byte_valid /
//   byte_ready. output channel: one result per finished sequence on
//   code_point, byte_count and error_flags, handshake result_valid /
//   result_ready. a byte that only extends a sequence gives no result.
// throughput: one byte per cycle, sustained as long as result_ready is high.
//   the decoder state update is combinational logic around its state registers
//   and is the loop that sets this figure.
// path: an accepted byte enters the two-entry queue; the decoder takes it
//   from the queue head and, for the byte that ends its sequence, loads the
//   result register that drives result_valid.
// stall: the result register holds its value while result_ready is low; the
//   decoder then stops taking bytes and the queue absorbs up to two more
//   before byte_ready drops.
// reset: rst_n clears the queue, the sequence state and the result valid;
//   the decoder then waits for a lead byte.
module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_in,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [20:0] code_point,
    output logic [2:0]  byte_count,
    output logic [3:0]  error_flags
);
    import utf8sd_pkg::*;

    // classified byte into the queue
    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;

    // queue head into the decoder
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;

    utf8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    utf8sd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // sequence tracking and result register
    utf8sd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_point   (code_point),
        .byte_count   (byte_count),
        .error_flags  (error_flags)
    );

endmodule

/* hdl/utf8sd_front.sv */
// front end: takes raw bytes and tags each with its class
module utf8sd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [7:0]                  byte_in,
    output logic                        push_valid,
    input  logic                        push_ready,
    output utf8sd_pkg::queue_entry_t    push_entry
);
    import utf8sd_pkg::*;

    assign byte_ready      = push_ready;
    assign push_valid      = byte_valid;
    assign push_entry.data = byte_in;
    assign push_entry.cls  = classify(byte_in);

    // a tagged request must agree with the raw byte it came from
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_entry.cls == CLS_ASCII) == (push_entry.data[7] == 1'b0))
        else $error("ascii class does not match bit 7");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_entry.cls == CLS_CONT) |-> (push_entry.data[7:6] == 2'b10))
        else $error("continuation class on a non-continuation byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_entry.cls == CLS_BAD) |-> (push_entry.data[7:3] == 5'h1F))
        else $error("invalid class on a valid lead pattern");

endmodule

/* hdl/utf8sd_queue.sv */
// short queue between the classifier and the decoder
module utf8sd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    output logic                        push_ready,
    input  utf8sd_pkg::queue_entry_t    push_entry,
    output logic                        pop_valid,
    input  logic                        pop_ready,
    output utf8sd_pkg::queue_entry_t    pop_entry
);
    import utf8sd_pkg::*;

    queue_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

/* hdl/utf8sd_back.sv */
// back end: sequence state machine and result register
module utf8sd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  utf8sd_pkg::queue_entry_t    pop_entry,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [20:0]                 code_point,
    output logic [2:0]                  byte_count,
    output logic [3:0]                  error_flags
);
    import utf8sd_pkg::*;

    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CP_W-1:0]    acc_reg, acc_next;
    byte_class_t        lead_class_reg, lead_class_next;
    logic [CNT_W-1:0]   bytes_reg, bytes_next;
    logic               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]    code_point_reg;
    logic [CNT_W-1:0]   byte_count_reg;
    logic [FLAG_W-1:0]  error_flags_reg;

    logic               pop;
    logic               emit;
    logic               invalid;
    logic [REM_W-1:0]   rem_w;
    logic [CP_W-1:0]    acc_w;
    byte_class_t        cls_w;
    logic [CNT_W-1:0]   bytes_w;
    logic [FLAG_W-1:0]  flags_w;

    assign pop_ready    = !out_valid_reg || result_ready;
    assign pop          = pop_valid && pop_ready;
    assign result_valid = out_valid_reg;
    assign code_point   = code_point_reg;
    assign byte_count   = byte_count_reg;
    assign error_flags  = error_flags_reg;

    always_comb
    begin
        emit    = 1'b0;
        invalid = 1'b0;
        rem_w   = rem_reg;
        acc_w   = acc_reg;
        cls_w   = lead_class_reg;
        bytes_w = bytes_reg;
        if (pop)
        begin
            if (rem_reg == '0)
            begin
                // lead byte
                cls_w   = pop_entry.cls;
                acc_w   = CP_W'(pop_entry.data & lead_mask(pop_entry.cls));
                bytes_w = CNT_W'(1);
                if (pop_entry.cls inside {CLS_LEAD2, CLS_LEAD3, CLS_LEAD4})
                begin
                    rem_w = REM_W'(pop_entry.cls - 3'd1);
                end
                else
                begin
                    emit    = 1'b1;
                    invalid = (pop_entry.cls == CLS_CONT) || (pop_entry.cls == CLS_BAD);
                end
            end
            else
            begin
                // any later byte shifts in, proper continuation or not
                bytes_w = bytes_reg + 1'b1;
                acc_w   = {acc_reg[CP_W-7:0], pop_entry.data[5:0]};
                if (pop_entry.cls == CLS_CONT)
                begin
                    rem_w = rem_reg - 1'b1;
                    emit  = (rem_w == '0);
                end
                else
                begin
                    rem_w   = '0;
                    emit    = 1'b1;
                    invalid = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        flags_w                 = '0;
        flags_w[FLAG_INVALID]   = invalid;
        flags_w[FLAG_OVERLONG]  = is_overlong(cls_w, acc_w);
        flags_w[FLAG_SURROGATE] = (acc_w[CP_W-1:11] == SURROGATE_HIGH);
        flags_w[FLAG_RANGE]     = (acc_w > MAX_SCALAR);
    end

    always_comb
    begin
        if (emit)
        begin
            rem_next        = '0;
            acc_next        = '0;
            lead_class_next = CLS_CONT;
            bytes_next      = '0;
        end
        else
        begin
            rem_next        = rem_w;
            acc_next        = acc_w;
            lead_class_next = cls_w;
            bytes_next      = bytes_w;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            acc_reg        <= '0;
            lead_class_reg <= CLS_CONT;
            bytes_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rem_reg        <= rem_next;
            acc_reg        <= acc_next;
            lead_class_reg <= lead_class_next;
            bytes_reg      <= bytes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_point_reg  <= acc_w;
            byte_count_reg  <= bytes_w;
            error_flags_reg <= flags_w;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> (bytes_reg != '0) && (({1'b0, rem_reg} + bytes_reg) <= CNT_W'(4)))
        else $error("sequence length beyond four bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) |-> (acc_reg == '0) && (bytes_reg == '0))
        else $error("idle state not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (byte_count_reg >= CNT_W'(1)) && (byte_count_reg <= CNT_W'(4)))
        else $error("result byte count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !pop)
        else $error("byte taken while result is stalled");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the utf-8 stream decoder: byte driver, result monitor, decode model
`timescale 1ns / 100ps

module testbench;
    import utf8sd_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [CNT_W-1:0]  count;
        logic [FLAG_W-1:0] flags;
    } char_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              byte_valid = 1'b0;
    logic              byte_ready;
    logic [7:0]        byte_in = 8'h00;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [CP_W-1:0]   code_point;
    logic [CNT_W-1:0]  byte_count;
    logic [FLAG_W-1:0] error_flags;

    // stimulus bytes not yet offered, and decoded characters not yet seen
    logic [7:0]   bytes_to_send[$];
    char_result_t chars_awaited[$];

    // decode model state
    logic [REM_W-1:0] seq_left = '0;
    logic [CP_W-1:0]  seq_value = '0;
    byte_class_t      seq_class = CLS_CONT;
    logic [CNT_W-1:0] seq_count = '0;

    int   send_idle_pct = 23;
    int   recv_idle_pct = 88;
    int   mismatch_count = 0;
    logic byte_took = 1'b0;
    logic stall_req = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    utf8_stream_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_in      (byte_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_point   (code_point),
        .byte_count   (byte_count),
        .error_flags  (error_flags)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // class of a byte from its leading bits
    function automatic byte_class_t byte_kind(input logic [7:0] b);
        byte_class_t k;
        case (b) inside
            8'b0???????: k = CLS_ASCII;
            8'b10??????: k = CLS_CONT;
            8'b110?????: k = CLS_LEAD2;
            8'b1110????: k = CLS_LEAD3;
            8'b11110???: k = CLS_LEAD4;
            default:     k = CLS_BAD;
        endcase
        return k;
    endfunction

    // advance the decode model by one accepted byte, queue a character when a sequence ends
    task automatic decode_byte(input logic [7:0] b);
        byte_class_t  k;
        logic         done;
        logic         bad;
        logic         low;
        char_result_t r;
        k = byte_kind(b);
        done = 1'b0;
        bad = 1'b0;
        if (seq_left == '0)
        begin
            seq_class = k;
            seq_count = 3'd1;
            case (k)
                CLS_ASCII: seq_value = {14'd0, b[6:0]};
                CLS_LEAD2: seq_value = {16'd0, b[4:0]};
                CLS_LEAD3: seq_value = {17'd0, b[3:0]};
                CLS_LEAD4: seq_value = {18'd0, b[2:0]};
                default:   seq_value = '0;
            endcase
            if (k == CLS_LEAD2 || k == CLS_LEAD3 || k == CLS_LEAD4)
                seq_left = REM_W'(int'(k) - 1);
            else
            begin
                done = 1'b1;
                bad = (k == CLS_CONT || k == CLS_BAD);
            end
        end
        else
        begin
            seq_count = seq_count + 3'd1;
            seq_value = {seq_value[CP_W-7:0], b[5:0]};
            if (k == CLS_CONT)
            begin
                seq_left = seq_left - 2'd1;
                done = (seq_left == '0);
            end
            else
            begin
                // any other byte breaks the sequence and is consumed by it
                seq_left = '0;
                done = 1'b1;
                bad = 1'b1;
            end
        end
        if (done)
        begin
            case (seq_class)
                CLS_CONT:  low = 1'b1;
                CLS_LEAD2: low = (seq_value < MIN_TWO_BYTE);
                CLS_LEAD3: low = (seq_value < MIN_THREE_BYTE);
                CLS_LEAD4: low = (seq_value < MIN_FOUR_BYTE);
                default:   low = 1'b0;
            endcase
            r.cp = seq_value;
            r.count = seq_count;
            r.flags = '0;
            r.flags[FLAG_INVALID] = bad;
            r.flags[FLAG_OVERLONG] = low;
            r.flags[FLAG_SURROGATE] = (seq_value[CP_W-1:11] == SURROGATE_HIGH);
            r.flags[FLAG_RANGE] = (seq_value > MAX_SCALAR);
            chars_awaited.push_back(r);
            seq_left = '0;
            seq_value = '0;
            seq_class = CLS_CONT;
            seq_count = '0;
        end
    endtask

    // byte driver: new request at the falling edge once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_took))
        begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_valid <= 1'b1;
                byte_in <= bytes_to_send.pop_front();
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result receiver: random idling, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (stall_seen != stall_req)
        begin
            stall_seen <= stall_req;
            stall_left <= 120;
            result_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: model accepted bytes and check accepted characters
    always @(posedge clk)
    begin
        char_result_t e;
        byte_took <= byte_valid && byte_ready;
        if (result_valid && result_ready)
        begin
            if (chars_awaited.size() == 0)
            begin
                $display("%0t: unexpected character cp=%h count=%0d flags=%b",
                         $time, code_point, byte_count, error_flags);
                mismatch_count++;
            end
            else
            begin
                e = chars_awaited.pop_front();
                if (code_point !== e.cp)
                begin
                    $display("%0t: code_point expected %h actual %h", $time, e.cp, code_point);
                    mismatch_count++;
                end
                if (byte_count !== e.count)
                begin
                    $display("%0t: byte_count expected %0d actual %0d",
                             $time, e.count, byte_count);
                    mismatch_count++;
                end
                if (error_flags !== e.flags)
                begin
                    $display("%0t: error_flags expected %b actual %b",
                             $time, e.flags, error_flags);
                    mismatch_count++;
                end
            end
        end
        if (byte_valid && byte_ready)
            decode_byte(byte_in);
    end

    // random stream: mostly well-formed sequences, some cut short, some raw noise
    task automatic add_random_bytes(input int n);
        int          added;
        int          pick;
        int          len;
        int          conts;
        logic [7:0]  b;
        logic [7:0]  odd_leads[6];
        odd_leads = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4};
        added = 0;
        while (added < n)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                len = $urandom_range(4, 1);
                if (len > 1 && $urandom_range(3) == 0)
                begin
                    b = odd_leads[$urandom_range(5)];
                    len = (b < 8'hE0) ? 2 : (b < 8'hF0) ? 3 : 4;
                end
                else
                    case (len)
                        1:       b = 8'($urandom_range(8'h7F, 8'h00));
                        2:       b = 8'($urandom_range(8'hDF, 8'hC0));
                        3:       b = 8'($urandom_range(8'hEF, 8'hE0));
                        default: b = 8'($urandom_range(8'hF7, 8'hF0));
                    endcase
                bytes_to_send.push_back(b);
                added++;
                // well-formed unless cut short by a non-continuation byte
                conts = (pick < 70 || len == 1) ? len - 1 : $urandom_range(len - 2, 0);
                for (int i = 0; i < conts; i++)
                begin
                    bytes_to_send.push_back(8'($urandom_range(8'hBF, 8'h80)));
                    added++;
                end
                if (conts < len - 1)
                begin
                    if ($urandom_range(1) == 0)
                        b = 8'($urandom_range(8'h7F, 8'h00));
                    else
                        b = 8'($urandom_range(8'hFF, 8'hC0));
                    bytes_to_send.push_back(b);
                    added++;
                end
            end
            else
            begin
                bytes_to_send.push_back(8'($urandom_range(255)));
                added++;
            end
        end
    endtask

    // let the sender run dry and every character come back
    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || byte_valid)
            @(posedge clk);
        while (chars_awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] directed[$];
        // ascii extremes, stray continuation, never-valid leads, overlong forms,
        // surrogate, above range, rejection by ascii and by a new lead
        directed = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
                     8'hC0, 8'h80, 8'hDF, 8'hBF,
                     8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
                     8'hF4, 8'h90, 8'h80, 8'h80,
                     8'hC3, 8'h41, 8'hE2, 8'h82, 8'hF0, 8'hBF};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            bytes_to_send.push_back(directed[i]);
        add_random_bytes(380);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 23;
        add_random_bytes(380);
        wait_drained();

        // no idling; the receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req <= ~stall_req;
        add_random_bytes(380);
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hdl/utf8sd_pkg.sv
hdl/utf8sd_front.sv
hdl/utf8sd_queue.sv
hdl/utf8sd_back.sv
hdl/utf8_stream_decoder.sv
verif/testbench.sv
